[hdl/qdlw_pkg.sv]
// Package for the queued DDA line walker: commands, result kinds, line modes,
// controller states and the command/status structs. No dependencies.
package qdlw_pkg;

	localparam int QueueDepth = 8;
	localparam int QidxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QcntW      = $clog2(QueueDepth + 1);
	localparam int FracBits   = 16;
	localparam int ExactW     = 10 + FracBits;
	localparam int NumW       = 10 + FracBits + 1;
	localparam int DivCntW    = $clog2(NumW + 1);

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_WALK_ABS = 3'd1,
		CMD_WALK_REL = 3'd2,
		CMD_TELEPORT = 3'd3,
		CMD_ABANDON  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TRAIL  = 2'd0,
		KIND_MARKER = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_HORIZ = 2'd1,
		MODE_VERT  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_FINISH,
		ST_STEP,
		ST_OUT_TRAIL0,
		ST_OUT_MARKER,
		ST_OUT_TRAIL1,
		ST_OUT_ONE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       exec;
		logic       load;
		logic       prep;
		logic       div_step;
		logic       finish;
		logic       step;
		logic       emit;
		kind_t      emit_kind;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t  cmd;
		logic  walking;
		logic  queue_nonempty;
		logic  task_live;
		logic  div_done;
		logic  trail_on;
		logic  line_ends;
		logic  out_busy;
	} dp_status_t;

endpackage

[hdl/qdlw_datapath.sv]
// Datapath of the queued DDA line walker: queue memory, cursor and line
// registers, serial slope divider and the result register. Uses qdlw_pkg.
module qdlw_datapath import qdlw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic [2:0]       command,
	input  logic [7:0]       target_x,
	input  logic [7:0]       target_y,
	input  logic signed [7:0] delta_x,
	input  logic signed [7:0] delta_y,
	input  logic [23:0]      trail_color,
	input  logic [7:0]       speed,
	input  logic [23:0]      transparent_code,
	input  logic [23:0]      marker_color,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       write_kind,
	output logic signed [9:0] pix_x,
	output logic signed [9:0] pix_y,
	output logic [23:0]      pix_color,
	output logic [7:0]       speed_out,
	output logic             accepted,
	output logic             busy_res,
	output logic             last
);

	localparam int EntryW = 1 + 8 + 8 + 24 + 8;

	// captured input beat
	logic [2:0]  in_cmd_q;
	logic [7:0]  in_x_q, in_y_q, in_dx_q, in_dy_q, in_spd_q;
	logic [23:0] in_col_q;

	logic [9:0]        cursor_x_q, cursor_y_q, steps_left_q;
	logic [ExactW-1:0] exact_x_q, exact_y_q, step_x_q, step_y_q;
	mode_t             mode_q;
	logic [23:0]       line_color_q;
	logic [7:0]        line_speed_q;
	logic [QidxW-1:0]  head_q;
	logic [QcntW-1:0]  count_q;
	logic              acc_q;

	logic [EntryW-1:0] mem [QueueDepth];
	logic [EntryW-1:0] rd_q;

	// task set-up
	logic              live_q, minor_neg_q, major_neg_q, vert_q;
	logic [9:0]        major_q;
	logic [NumW-1:0]   rem_q;
	logic [FracBits+1:0] quo_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic [23:0]       t_col_q;
	logic [7:0]        t_spd_q;

	logic [QidxW-1:0] tail;
	logic [QcntW:0]   tail_sum;
	logic             full, abs_same;
	assign tail_sum = {1'b0, count_q} + {{(QcntW+1-QidxW){1'b0}}, head_q};
	assign tail     = (tail_sum >= (QcntW+1)'(QueueDepth)) ?
		QidxW'(tail_sum - (QcntW+1)'(QueueDepth)) : QidxW'(tail_sum);
	assign full     = (count_q == QcntW'(QueueDepth));
	assign abs_same = ({2'b00, in_x_q} == cursor_x_q) && ({2'b00, in_y_q} == cursor_y_q);

	// task load decode
	logic [9:0] dest_x, dest_y, dx, dy, ax, ay;
	always_comb begin
		if (rd_q[EntryW-1]) begin
			dest_x = cursor_x_q + {{2{rd_q[47]}}, rd_q[47:40]};
			dest_y = cursor_y_q + {{2{rd_q[39]}}, rd_q[39:32]};
		end else begin
			dest_x = {2'b00, rd_q[47:40]};
			dest_y = {2'b00, rd_q[39:32]};
		end
		dx = dest_x - cursor_x_q;
		dy = dest_y - cursor_y_q;
		ax = dx[9] ? (10'd0 - dx) : dx;
		ay = dy[9] ? (10'd0 - dy) : dy;
	end

	// divider: numerator n*2^(F+1)+m, divisor 2m, one quotient bit a cycle
	logic [NumW-1:0] div2;
	logic [NumW-1:0] num_q;
	logic [NumW:0]   shifted;
	assign div2    = NumW'({major_q, 1'b0});
	assign shifted = {rem_q, num_q[NumW-1]};

	// rounding of exact positions
	function automatic logic [9:0] round_e(input logic [ExactW-1:0] e);
		logic [ExactW-1:0] mag, sum;
		logic [9:0]        r;
		mag = e[ExactW-1] ? (ExactW'(0) - e) : e;
		sum = mag + ExactW'(1 << (FracBits - 1));
		r   = sum[ExactW-1:FracBits];
		return e[ExactW-1] ? (10'd0 - r) : r;
	endfunction

	logic [ExactW-1:0] nx, ny;
	assign nx = exact_x_q + step_x_q;
	assign ny = exact_y_q + step_y_q;

	assign status.cmd            = cmd_t'(in_cmd_q);
	assign status.walking        = (mode_q != MODE_IDLE);
	assign status.queue_nonempty = (count_q != '0);
	assign status.task_live      = live_q;
	assign status.div_done       = (div_cnt_q == '0);
	assign status.trail_on       = (line_color_q != transparent_code);
	assign status.line_ends      = (steps_left_q == 10'd1);
	assign status.out_busy       = out_valid;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_cmd_q <= command;
			in_x_q   <= target_x;
			in_y_q   <= target_y;
			in_dx_q  <= delta_x;
			in_dy_q  <= delta_y;
			in_col_q <= trail_color;
			in_spd_q <= speed;
		end
		if (cmd.exec && !full &&
		    ((in_cmd_q == CMD_WALK_REL) || (in_cmd_q == CMD_WALK_ABS && !abs_same))) begin
			if (in_cmd_q == CMD_WALK_REL)
				mem[tail] <= {1'b1, in_dx_q, in_dy_q, in_col_q, in_spd_q};
			else
				mem[tail] <= {1'b0, in_x_q, in_y_q, in_col_q, in_spd_q};
		end
		rd_q <= mem[head_q];
		if (cmd.prep) begin
			t_col_q     <= rd_q[31:8];
			t_spd_q     <= rd_q[7:0];
			vert_q      <= (ay > ax);
			major_q     <= (ay > ax) ? ay : ax;
			major_neg_q <= (ay > ax) ? dy[9] : dx[9];
			minor_neg_q <= (ay > ax) ? dx[9] : dy[9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.prep) begin
			div_cnt_q <= DivCntW'(NumW);
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q <= (NumW'((ay > ax) ? ax : ay) << (FracBits + 1)) |
				NumW'((ay > ax) ? ay : ax);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (shifted >= {1'b0, div2}) begin
				rem_q <= NumW'(shifted - {1'b0, div2});
				quo_q <= {quo_q[FracBits:0], 1'b1};
			end else begin
				rem_q <= shifted[NumW-1:0];
				quo_q <= {quo_q[FracBits:0], 1'b0};
			end
		end
	end

	logic [ExactW-1:0] sstep, mstep;
	assign sstep = minor_neg_q ? (ExactW'(0) - ExactW'(quo_q)) : ExactW'(quo_q);
	assign mstep = major_neg_q ? (ExactW'(0) - ExactW'(1 << FracBits)) :
		ExactW'(1 << FracBits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			exact_x_q    <= '0;
			exact_y_q    <= '0;
			step_x_q     <= '0;
			step_y_q     <= '0;
			steps_left_q <= '0;
			mode_q       <= MODE_IDLE;
			line_color_q <= '0;
			line_speed_q <= '0;
			head_q       <= '0;
			count_q      <= '0;
			acc_q        <= 1'b0;
			live_q       <= 1'b0;
		end else begin
			if (cmd.exec) begin
				case (in_cmd_q)
					CMD_WALK_ABS, CMD_WALK_REL: begin
						if (!full && (in_cmd_q == CMD_WALK_REL || !abs_same)) begin
							count_q <= count_q + QcntW'(1);
							acc_q   <= 1'b1;
						end else begin
							acc_q <= 1'b0;
						end
					end
					CMD_TELEPORT: begin
						cursor_x_q <= {2'b00, in_x_q};
						cursor_y_q <= {2'b00, in_y_q};
					end
					CMD_ABANDON: begin
						mode_q  <= MODE_IDLE;
						head_q  <= '0;
						count_q <= '0;
						acc_q   <= 1'b1;
					end
					default: acc_q <= 1'b0;
				endcase
			end
			if (cmd.load) begin
				// pop the head entry; its data arrives in rd_q next cycle
				head_q  <= (head_q == QidxW'(QueueDepth - 1)) ? '0 : head_q + QidxW'(1);
				count_q <= count_q - QcntW'(1);
			end
			if (cmd.prep) begin
				live_q <= (dx != 10'd0) || (dy != 10'd0);
			end
			if (cmd.finish) begin
				exact_x_q    <= {cursor_x_q, {FracBits{1'b0}}};
				exact_y_q    <= {cursor_y_q, {FracBits{1'b0}}};
				line_color_q <= t_col_q;
				line_speed_q <= t_spd_q;
				steps_left_q <= major_q;
				mode_q       <= vert_q ? MODE_VERT : MODE_HORIZ;
				step_x_q     <= vert_q ? sstep : mstep;
				step_y_q     <= vert_q ? mstep : sstep;
			end
			if (cmd.step) begin
				exact_x_q    <= nx;
				exact_y_q    <= ny;
				cursor_x_q   <= round_e(nx);
				cursor_y_q   <= round_e(ny);
				steps_left_q <= steps_left_q - 10'd1;
				if (steps_left_q == 10'd1)
					mode_q <= MODE_IDLE;
			end
		end
	end

	// result register; trail-before-step uses the old cursor, held in old_*
	logic [9:0] old_x_q, old_y_q;
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			old_x_q <= cursor_x_q;
			old_y_q <= cursor_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			write_kind <= cmd.emit_kind;
			last       <= cmd.emit_last;
			busy_res   <= (mode_q != MODE_IDLE);
			accepted   <= 1'b0;
			speed_out  <= line_speed_q;
			pix_x      <= cursor_x_q;
			pix_y      <= cursor_y_q;
			case (cmd.emit_kind)
				KIND_TRAIL: begin
					pix_color <= line_color_q;
					if (!cmd.emit_last || steps_left_q != 10'd0) begin
						pix_x <= old_x_q;
						pix_y <= old_y_q;
					end
				end
				KIND_MARKER: begin
					pix_color <= marker_color;
					if (in_cmd_q == CMD_TELEPORT)
						speed_out <= '0;
				end
				default: begin
					pix_color <= '0;
					speed_out <= '0;
					accepted  <= acc_q;
				end
			endcase
		end
	end

endmodule

[hdl/qdlw_ctrl.sv]
// Controller of the queued DDA line walker: sequences command execution,
// task start with serial division, line steps and result beats. Uses qdlw_pkg.
module qdlw_ctrl import qdlw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a beat may only be loaded when the result register is free or leaving
	logic out_free;
	assign out_free = !status.out_busy || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.emit_kind = KIND_STATUS;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.cmd == CMD_TICK) begin
					if (status.walking) begin
						state_d = ST_STEP;
					end else if (status.queue_nonempty) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.exec = 1'b1;
					state_d  = ST_OUT_ONE;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (!status.task_live) begin
					state_d = ST_IDLE;
				end else if (status.div_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = status.trail_on ? ST_OUT_TRAIL0 : ST_OUT_MARKER;
			end
			ST_OUT_TRAIL0: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_TRAIL;
					state_d       = ST_OUT_MARKER;
				end
			end
			ST_OUT_MARKER: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_MARKER;
					cmd.emit_last = status.walking || !status.trail_on;
					state_d       = cmd.emit_last ? ST_IDLE : ST_OUT_TRAIL1;
				end
			end
			ST_OUT_TRAIL1: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_TRAIL;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_OUT_ONE: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = (status.cmd == CMD_TELEPORT) ? KIND_MARKER : KIND_STATUS;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hdl/queued_dda_line_walker.sv]
// Top level of the queued DDA line walker: APB register file, controller and
// datapath. Uses qdlw_pkg, qdlw_ctrl and qdlw_datapath.
//
// A walk, teleport or abandon command goes from capture through execution to
// its single result beat. A tick that steps the line goes through capture and
// the step state to up to three beats, which leave at one beat a cycle while
// out_ready stays high. A tick that starts a task pops the queue and runs
// a restoring slope divider, one quotient bit a cycle, and yields no beat. One
// item is in flight at a time; the result register frees the output.
module queued_dda_line_walker import qdlw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             valid,
	output logic             ready,
	input  logic [2:0]       command,
	input  logic [7:0]       target_x,
	input  logic [7:0]       target_y,
	input  logic signed [7:0] delta_x,
	input  logic signed [7:0] delta_y,
	input  logic [23:0]      trail_color,
	input  logic [7:0]       speed,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       write_kind,
	output logic signed [9:0] pix_x,
	output logic signed [9:0] pix_y,
	output logic [23:0]      pix_color,
	output logic [7:0]       speed_out,
	output logic             accepted,
	output logic             busy_res,
	output logic             last
);

	localparam logic [2:0] AddrTransparent = 3'd0;
	localparam logic [2:0] AddrMarker      = 3'd4;

	logic [23:0] transparent_q, marker_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_q <= '0;
			marker_q      <= 24'h00FF00;
		end else if (wr) begin
			if (paddr == AddrTransparent)
				transparent_q <= pwdata[23:0];
			else if (paddr == AddrMarker)
				marker_q <= pwdata[23:0];
		end
	end

	always_comb begin
		case (paddr)
			AddrTransparent: prdata = {8'd0, transparent_q};
			AddrMarker:      prdata = {8'd0, marker_q};
			default:         prdata = '0;
		endcase
	end

	dp_cmd_t    cmd;
	dp_status_t status;

	qdlw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid),
		.in_ready  (ready),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	qdlw_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.command          (command),
		.target_x         (target_x),
		.target_y         (target_y),
		.delta_x          (delta_x),
		.delta_y          (delta_y),
		.trail_color      (trail_color),
		.speed            (speed),
		.transparent_code (transparent_q),
		.marker_color     (marker_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.write_kind       (write_kind),
		.pix_x            (pix_x),
		.pix_y            (pix_y),
		.pix_color        (pix_color),
		.speed_out        (speed_out),
		.accepted         (accepted),
		.busy_res         (busy_res),
		.last             (last)
	);

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for queued_dda_line_walker: drives commands, walks and
// ticks, predicts every pixel write and status beat. Depends on qdlw_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top import qdlw_pkg::*; ();

	localparam logic [2:0] RegTransparent = 3'd0;
	localparam logic [2:0] RegMarker      = 3'd4;
	localparam logic [2:0] CmdTopKnown    = CMD_ABANDON;
	localparam int         DrainCycles    = 64;
	localparam int         HoldCycles     = 300;

	typedef struct {
		kind_t             kind;
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic [23:0]       color;
		logic [7:0]        spd;
		logic              acc;
		logic              busy;
		logic              last;
	} pixel_write_t;

	typedef struct {
		logic        rel;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [23:0] color;
		logic [7:0]  spd;
	} walk_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic valid, ready, out_valid, out_ready;
	logic [2:0]  command;
	logic [7:0]  target_x, target_y, speed;
	logic signed [7:0] delta_x, delta_y;
	logic [23:0] trail_color, pix_color;
	logic [1:0]  write_kind;
	logic signed [9:0] pix_x, pix_y;
	logic [7:0]  speed_out;
	logic accepted, busy_res, last;

	// predictor state
	logic [23:0] transp_code, marker_col;
	logic [9:0]  cur_x, cur_y, steps_left;
	logic [25:0] exact_x, exact_y, step_x, step_y;
	mode_t       line_mode;
	logic [23:0] line_col;
	logic [7:0]  line_spd;
	walk_t       walk_q [QueueDepth];
	int          q_head, q_count;

	pixel_write_t expected_writes [$];
	int errors, items_sent, hold_cnt;
	bit quiet;

	queued_dda_line_walker DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [9:0] round_pos(logic [25:0] e);
		longint s, r;
		s = longint'($signed(e));
		if (s >= 0) r = (s + 32768) >>> FracBits;
		else r = -((-s + 32768) >>> FracBits);
		return r[9:0];
	endfunction

	function automatic pixel_write_t mk(kind_t k, logic [9:0] x, logic [9:0] y,
			logic [23:0] c, logic [7:0] s, logic a);
		pixel_write_t w;
		w.kind = k; w.x = x; w.y = y; w.color = c; w.spd = s; w.acc = a;
		w.busy = 0; w.last = 0;
		return w;
	endfunction

	function automatic void start_walk();
		walk_t t;
		logic [9:0] dest_x, dest_y, d10;
		longint dx, dy, major, minor, m, n, q;
		logic [25:0] sstep, mstep;
		if (q_count == 0) return;
		t = walk_q[q_head];
		q_head = (q_head + 1) % QueueDepth;
		q_count--;
		if (t.rel) begin
			dest_x = cur_x + {{2{t.x[7]}}, t.x};
			dest_y = cur_y + {{2{t.y[7]}}, t.y};
		end else begin
			dest_x = {2'b00, t.x};
			dest_y = {2'b00, t.y};
		end
		d10 = dest_x - cur_x; dx = longint'($signed(d10));
		d10 = dest_y - cur_y; dy = longint'($signed(d10));
		if (dx == 0 && dy == 0) return;
		exact_x = {cur_x, 16'd0};
		exact_y = {cur_y, 16'd0};
		line_col = t.color;
		line_spd = t.spd;
		if ((dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx)) begin
			major = dy; minor = dx; line_mode = MODE_VERT;
		end else begin
			major = dx; minor = dy; line_mode = MODE_HORIZ;
		end
		m = major < 0 ? -major : major;
		n = minor < 0 ? -minor : minor;
		q = ((n << (FracBits + 1)) + m) / (2 * m);
		sstep = minor < 0 ? 26'(-q) : 26'(q);
		mstep = major < 0 ? 26'(-65536) : 26'(65536);
		steps_left = m[9:0];
		if (line_mode == MODE_VERT) begin
			step_y = mstep; step_x = sstep;
		end else begin
			step_x = mstep; step_y = sstep;
		end
	endfunction

	function automatic void predict_beats(logic [2:0] cmd, logic [7:0] tx, logic [7:0] ty,
			logic [7:0] dx, logic [7:0] dy, logic [23:0] col, logic [7:0] spd);
		pixel_write_t w [3];
		int n;
		logic acc, trail;
		n = 0; acc = 0;
		case (cmd)
			CMD_TICK: begin
				if (line_mode != MODE_IDLE) begin
					trail = line_col != transp_code;
					if (trail) w[n++] = mk(KIND_TRAIL, cur_x, cur_y, line_col, line_spd, 0);
					exact_x += step_x;
					exact_y += step_y;
					cur_x = round_pos(exact_x);
					cur_y = round_pos(exact_y);
					w[n++] = mk(KIND_MARKER, cur_x, cur_y, marker_col, line_spd, 0);
					steps_left--;
					if (steps_left == 0) begin
						if (trail) w[n++] = mk(KIND_TRAIL, cur_x, cur_y, line_col, line_spd, 0);
						line_mode = MODE_IDLE;
					end
				end else start_walk();
			end
			CMD_WALK_ABS, CMD_WALK_REL: begin
				if ((cmd == CMD_WALK_REL || !(tx == cur_x && ty == cur_y))
						&& q_count < QueueDepth) begin
					walk_q[(q_head + q_count) % QueueDepth] = '{cmd == CMD_WALK_REL,
						cmd == CMD_WALK_REL ? dx : tx, cmd == CMD_WALK_REL ? dy : ty, col, spd};
					q_count++;
					acc = 1;
				end
				w[n++] = mk(KIND_STATUS, cur_x, cur_y, 0, 0, acc);
			end
			CMD_TELEPORT: begin
				cur_x = {2'b00, tx};
				cur_y = {2'b00, ty};
				w[n++] = mk(KIND_MARKER, cur_x, cur_y, marker_col, 0, 0);
			end
			CMD_ABANDON: begin
				line_mode = MODE_IDLE;
				q_head = 0;
				q_count = 0;
				w[n++] = mk(KIND_STATUS, cur_x, cur_y, 0, 0, 1);
			end
			default: w[n++] = mk(KIND_STATUS, cur_x, cur_y, 0, 0, 0);
		endcase
		for (int k = 0; k < n; k++) begin
			w[k].busy = line_mode != MODE_IDLE;
			w[k].last = k == n - 1;
			expected_writes.push_back(w[k]);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_write_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_writes.size() == 0) report("unexpected beat", write_kind, 0);
			else begin
				w = expected_writes.pop_front();
				if (write_kind !== w.kind) report("write_kind", write_kind, w.kind);
				if (pix_x !== w.x) report("pix_x", pix_x, w.x);
				if (pix_y !== w.y) report("pix_y", pix_y, w.y);
				if (pix_color !== w.color) report("pix_color", pix_color, w.color);
				if (speed_out !== w.spd) report("speed_out", speed_out, w.spd);
				if (accepted !== w.acc) report("accepted", accepted, w.acc);
				if (busy_res !== w.busy) report("busy_res", busy_res, w.busy);
				if (last !== w.last) report("last", last, w.last);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_ready = 0;
			hold_cnt--;
		end else out_ready = quiet ? 1'b1 : ($urandom_range(99) >= 23);
	end

	task automatic send_item(logic [2:0] cmd, logic [7:0] tx, logic [7:0] ty, logic [7:0] dx,
			logic [7:0] dy, logic [23:0] col, logic [7:0] spd);
		if (!quiet && $urandom_range(99) < 23) begin
			valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		command = cmd; target_x = tx; target_y = ty; delta_x = dx; delta_y = dy;
		trail_color = col; speed = spd; valid = 1;
		do @(posedge clk); while (!ready);
		predict_beats(cmd, tx, ty, dx, dy, col, spd);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_rand(logic [2:0] cmd);
		send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			24'($urandom), 8'($urandom));
	endtask

	task automatic walk_rel(logic [7:0] dx, logic [7:0] dy, logic [23:0] col);
		send_item(CMD_WALK_REL, 8'($urandom), 8'($urandom), dx, dy, col, 8'($urandom));
	endtask

	task automatic walk_abs(logic [7:0] tx, logic [7:0] ty, logic [23:0] col);
		send_item(CMD_WALK_ABS, tx, ty, 8'($urandom), 8'($urandom), col, 8'($urandom));
	endtask

	// tick until the line and the queue are done, or give up after cap ticks
	task automatic run_ticks(int cap);
		for (int i = 0; i < cap && (line_mode != MODE_IDLE || q_count != 0); i++)
			send_rand(CMD_TICK);
	endtask

	task automatic wait_idle();
		valid = 0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [23:0] value);
		psel = 1; pwrite = 1; penable = 0; paddr = addr;
		pwdata = {8'($urandom_range(255)), value};
		@(negedge clk) penable = 1;
		@(posedge clk);
		@(negedge clk) pwrite = 0; penable = 0;
		if (addr == RegTransparent) transp_code = value;
		else marker_col = value;
		@(negedge clk) penable = 1;
		@(posedge clk);
		if (prdata[23:0] !== value) report("register readback", prdata, value);
		@(negedge clk) psel = 0; penable = 0;
	endtask

	task automatic test_extremes();
		write_reg(RegTransparent, 24'h123456);
		write_reg(RegMarker, 24'hFFFFFF);
		walk_abs(0, 0, 24'hFFFFFF);          // dropped: already there
		walk_abs(8'd3, 8'd1, 24'hFFFFFF);
		walk_rel(8'h80, 8'h7F, 24'h000001);  // shallow, negative major
		walk_rel(8'h00, 8'h00, 24'hABCDEF);  // zero displacement, discarded
		walk_rel(8'd2, 8'd2, 24'h123456);    // transparent trail
		run_ticks(400);
		send_item(CMD_TELEPORT, 8'hFF, 8'hFF, 0, 0, 0, 8'hFF);
		walk_abs(8'hC0, 8'h80, 24'h800000);  // vertical major, both axes negative
		run_ticks(400);
		for (int k = 1; k <= 3; k++) send_rand(CmdTopKnown + 3'(k));
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < QueueDepth + 1; i++)
			walk_rel(8'($urandom_range(1, 4)), 0, 24'($urandom));
		send_rand(CMD_TICK);
		send_rand(CMD_TICK);
		send_rand(CMD_ABANDON);
		send_rand(CMD_TICK);
		walk_rel(8'hFF, 8'h01, 24'h00FF00);
		run_ticks(40);
	endtask

	task automatic test_backpressure();
		hold_cnt = HoldCycles;
		for (int i = 0; i < 12; i++) send_rand(i % 2 ? CMD_TELEPORT : CMD_WALK_REL);
		send_rand(CMD_ABANDON);
	endtask

	task automatic test_random(int count);
		int stop, r;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			quiet = items_sent % 100 < 30;
			if (r < 70) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(9) < 8)
						walk_rel(8'($urandom_range(16) - 8), 8'($urandom_range(16) - 8),
							$urandom_range(3) == 0 ? transp_code : 24'($urandom));
					else walk_abs(8'($urandom), 8'($urandom), 24'($urandom));
				end
				run_ticks(60);
				if (line_mode != MODE_IDLE || q_count != 0) send_rand(CMD_ABANDON);
			end else if (r < 80) begin
				send_rand(CMD_TELEPORT);
			end else begin
				send_rand(3'($urandom_range(7)));
			end
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = RegTransparent; pwdata = 0;
		valid = 0; command = CMD_TICK; target_x = 0; target_y = 0; delta_x = 0; delta_y = 0;
		trail_color = 0; speed = 0;
		out_ready = 0; hold_cnt = 0; quiet = 0; errors = 0; items_sent = 0;
		transp_code = 0; marker_col = 24'h00FF00;
		cur_x = 0; cur_y = 0; exact_x = 0; exact_y = 0; step_x = 0; step_y = 0;
		steps_left = 0; line_mode = MODE_IDLE; line_col = 0; line_spd = 0;
		q_head = 0; q_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_extremes();
		test_full_queue();
		wait_idle();
		write_reg(RegTransparent, 24'hFFFFFF);
		write_reg(RegMarker, 24'h000000);
		test_backpressure();
		test_random(60);
		wait_idle();
		write_reg(RegTransparent, 24'h000000);
		write_reg(RegMarker, 24'($urandom));
		test_random(60);
		wait_idle();

		if (errors == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end

endmodule
